### hw/rtl/u16550_pkg.sv
package u16550_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		OP_READ    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_LINE_RX = 2'd2,
		OP_TX_SLOT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_DATA = 3'd0,
		REG_IER  = 3'd1,
		REG_ISR  = 3'd2,
		REG_LCR  = 3'd3,
		REG_LSR  = 3'd5
	} reg_ofs_t;

	localparam logic [3:0] IER_RX_DATA  = 4'(1 << 0);
	localparam logic [3:0] IER_TX_EMPTY = 4'(1 << 1);
	localparam logic [7:0] FCR_ENABLE   = 8'(1 << 0);
	localparam logic [7:0] FCR_CLR_RX   = 8'(1 << 1);
	localparam logic [7:0] FCR_CLR_TX   = 8'(1 << 2);
	localparam logic [7:0] LCR_DLAB     = 8'(1 << 7);
	localparam logic [7:0] ISR_RX_DATA  = 8'h04;
	localparam logic [7:0] ISR_TX_EMPTY = 8'h02;
	localparam logic [7:0] ISR_NONE     = 8'h01;
	localparam logic [7:0] ISR_FIFO_ON  = 8'hC0;
	localparam logic [7:0] LSR_DR       = 8'(1 << 0);
	localparam logic [7:0] LSR_OE       = 8'(1 << 1);
	localparam logic [7:0] LSR_TX_EMPTY = 8'h60;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic       deep;
		logic [7:0] wdata;
	} fifo_ctl_t;

	typedef struct packed {
		logic       empty;
		logic       full;
		logic       empty_next;
		logic [7:0] data;
	} fifo_stat_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       irq;
	} result_t;

endpackage

### hw/rtl/u16550_if.sv
interface u16550_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [2:0] reg_offset;
	logic [7:0] write_value;
	logic [7:0] line_byte;

	modport source (output valid, output opcode, output reg_offset, output write_value,
		output line_byte, input ready);
	modport sink (input valid, input opcode, input reg_offset, input write_value,
		input line_byte, output ready);
endinterface

interface u16550_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_value;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       irq;

	modport source (output valid, output read_value, output tx_valid, output tx_byte,
		output irq, input ready);
	modport sink (input valid, input read_value, input tx_valid, input tx_byte,
		input irq, output ready);
endinterface

### hw/rtl/u16550_fifo.sv
module u16550_fifo import u16550_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_ctl_t  ctl,
	output fifo_stat_t stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	logic [7:0]    mem_q [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW:0]   fill_q;
	logic [7:0]    data_q;

	logic [AW:0]   wsum;
	logic [AW:0]   wwrap;
	logic [AW-1:0] waddr;
	logic          full;
	logic          push_ok;
	logic          pop_ok;
	logic [AW-1:0] head_n;
	logic [AW:0]   fill_n;

	always_comb begin
		wsum    = {1'b0, head_q} + fill_q;
		wwrap   = (wsum >= DEPTH_W) ? (wsum - DEPTH_W) : wsum;
		waddr   = wwrap[AW-1:0];
		full    = ctl.deep ? (fill_q == DEPTH_W) : (fill_q != '0);
		push_ok = ctl.push && !ctl.clear && !full;
		pop_ok  = ctl.pop && !ctl.clear && (fill_q != '0);
		head_n  = head_q;
		fill_n  = fill_q;
		priority if (ctl.clear) begin
			head_n = '0;
			fill_n = '0;
		end else if (push_ok) begin
			fill_n = fill_q + 1'b1;
		end else if (pop_ok) begin
			head_n = (head_q == LAST) ? '0 : head_q + 1'b1;
			fill_n = fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			head_q <= head_n;
			fill_q <= fill_n;
		end
	end

	// keep the byte at the next head registered, bypassing a same-cycle write
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[waddr] <= ctl.wdata;
		end
		data_q <= (push_ok && waddr == head_n) ? ctl.wdata : mem_q[head_n];
	end

	assign stat.empty      = (fill_q == '0);
	assign stat.full       = full;
	assign stat.empty_next = (fill_n == '0);
	assign stat.data       = data_q;

endmodule

### hw/rtl/uart_16550_register_block_core.sv
// FIFO reads come from a registered head byte per FIFO. Results are registered
// in out_q, or in skid_q on a stall. Throughput: one item per cycle while skid_q
// is empty; a two-entry output buffer keeps req ready while one result waits on
// rsp. Reset (arst_n low, asynchronous): all CSRs, FIFO pointers and the overrun
// flag clear; FIFO storage is not cleared and is only read after it is written.
module uart_16550_register_block_core import u16550_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	u16550_req_if.sink   req,
	u16550_rsp_if.source rsp
);

	logic [15:0] dl_q;
	logic [3:0]  ier_q;
	logic [7:0]  lcr_q;
	logic        fifo_on_q;
	logic        ovr_q;

	fifo_ctl_t   rx_ctl;
	fifo_ctl_t   tx_ctl;
	fifo_stat_t  rx_stat;
	fifo_stat_t  tx_stat;

	result_t     res;
	result_t     out_q;
	result_t     skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	logic        acc;
	logic        dlab;
	logic [15:0] dl_n;
	logic [3:0]  ier_n;
	logic [7:0]  lcr_n;
	logic        fifo_on_n;
	logic        ovr_n;
	logic [7:0]  isr;
	logic        chg;

	u16550_fifo #(.DEPTH(FIFO_DEPTH)) rx_fifo (
		.clk(clk), .arst_n(arst_n), .ctl(rx_ctl), .stat(rx_stat)
	);

	u16550_fifo #(.DEPTH(FIFO_DEPTH)) tx_fifo (
		.clk(clk), .arst_n(arst_n), .ctl(tx_ctl), .stat(tx_stat)
	);

	assign req.ready = !skid_valid_q;
	assign acc       = req.valid && req.ready;
	assign dlab      = (lcr_q & LCR_DLAB) != '0;

	always_comb begin
		isr = ISR_NONE;
		priority if (((ier_q & IER_RX_DATA) != '0) && !rx_stat.empty) begin
			isr = ISR_RX_DATA;
		end else if (((ier_q & IER_TX_EMPTY) != '0) && tx_stat.empty) begin
			isr = ISR_TX_EMPTY;
		end
		if (fifo_on_q) begin
			isr = isr | ISR_FIFO_ON;
		end
	end

	always_comb begin
		dl_n      = dl_q;
		ier_n     = ier_q;
		lcr_n     = lcr_q;
		fifo_on_n = fifo_on_q;
		ovr_n     = ovr_q;
		chg       = 1'b0;
		rx_ctl    = '{push: 1'b0, pop: 1'b0, clear: 1'b0, deep: fifo_on_q,
			wdata: req.line_byte};
		tx_ctl    = '{push: 1'b0, pop: 1'b0, clear: 1'b0, deep: fifo_on_q,
			wdata: req.write_value};
		res       = '0;
		if (acc) begin
			unique case (op_t'(req.opcode))
				OP_READ: begin
					case (req.reg_offset)
						REG_DATA: begin
							if (dlab) begin
								res.read_value = dl_q[7:0];
							end else if (!rx_stat.empty) begin
								res.read_value = rx_stat.data;
								rx_ctl.pop     = 1'b1;
							end
						end
						REG_IER: begin
							res.read_value = dlab ? dl_q[15:8] : {4'b0, ier_q};
						end
						REG_ISR: res.read_value = isr;
						REG_LCR: res.read_value = lcr_q;
						REG_LSR: begin
							res.read_value = (rx_stat.empty ? 8'h00 : LSR_DR) |
								(ovr_q ? LSR_OE : 8'h00) |
								(tx_stat.empty ? LSR_TX_EMPTY : 8'h00);
							ovr_n = 1'b0;
						end
						default: res.read_value = '0;
					endcase
				end
				OP_WRITE: begin
					case (req.reg_offset)
						REG_DATA: begin
							if (dlab) begin
								dl_n[7:0] = req.write_value;
							end else begin
								tx_ctl.push = 1'b1;
							end
						end
						REG_IER: begin
							if (dlab) begin
								dl_n[15:8] = req.write_value;
							end else begin
								ier_n = req.write_value[3:0];
							end
						end
						REG_ISR: begin
							fifo_on_n    = (req.write_value & FCR_ENABLE) != '0;
							chg          = fifo_on_n != fifo_on_q;
							rx_ctl.clear = chg || ((req.write_value & FCR_CLR_RX) != '0);
							tx_ctl.clear = chg || ((req.write_value & FCR_CLR_TX) != '0);
						end
						REG_LCR: lcr_n = req.write_value;
						default: ;
					endcase
				end
				OP_LINE_RX: begin
					if (rx_stat.full) begin
						ovr_n = 1'b1;
					end else begin
						rx_ctl.push = 1'b1;
					end
				end
				OP_TX_SLOT: begin
					if (!tx_stat.empty) begin
						res.tx_valid = 1'b1;
						res.tx_byte  = tx_stat.data;
						tx_ctl.pop   = 1'b1;
					end
				end
			endcase
			res.irq = (((ier_n & IER_RX_DATA) != '0) && !rx_stat.empty_next) ||
				(((ier_n & IER_TX_EMPTY) != '0) && tx_stat.empty_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_q      <= '0;
			ier_q     <= '0;
			lcr_q     <= '0;
			fifo_on_q <= 1'b0;
			ovr_q     <= 1'b0;
		end else begin
			dl_q      <= dl_n;
			ier_q     <= ier_n;
			lcr_q     <= lcr_n;
			fifo_on_q <= fifo_on_n;
			ovr_q     <= ovr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || rsp.ready) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= acc;
				end
			end else if (acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || rsp.ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_q.read_value;
	assign rsp.tx_valid   = out_q.tx_valid;
	assign rsp.tx_byte    = out_q.tx_byte;
	assign rsp.irq        = out_q.irq;

endmodule

### hw/rtl/u16550_chk.sv
module u16550_chk import u16550_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] opcode,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] read_value,
	input logic       tx_valid,
	input logic [7:0] tx_byte
);

	logic acc;
	assign acc = req_valid && req_ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !tx_valid |-> tx_byte == 8'h00)
		else $error("tx_byte set without tx_valid");

	assert property (@(posedge clk) disable iff (!arst_n)
		acc && (!rsp_valid || rsp_ready) |=> rsp_valid)
		else $error("accepted item gave no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		acc && (!rsp_valid || rsp_ready) && opcode != OP_READ |=> read_value == 8'h00)
		else $error("read data on a non-read item");

	assert property (@(posedge clk) disable iff (!arst_n)
		acc && (!rsp_valid || rsp_ready) && opcode != OP_TX_SLOT |=> !tx_valid)
		else $error("tx byte on a non-transmit item");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(tx_byte))
		else $error("stalled item changed");

endmodule

bind uart_16550_register_block_core u16550_chk chk_i (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.opcode     (req.opcode),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.read_value (rsp.read_value),
	.tx_valid   (rsp.tx_valid),
	.tx_byte    (rsp.tx_byte)
);
